@@ sv/ritd_pkg.sv @@
`timescale 1ns / 1ps
package ritd_pkg;

	localparam int MAX_DIGITS_DEF = 64;

	localparam int VALUE_W = 64;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;
	localparam int COUNT_W = 7;
	localparam int CHUNK_W = 8;
	localparam int UPC_W   = 3;

	localparam int S_TDATA_W = ((VALUE_W + RADIX_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((CHAR_W + COUNT_W + 7) / 8) * 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

	// lower-case digit characters
	localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
	};

	// datapath operations
	localparam logic [2:0] OP_WAIT  = 3'd0;
	localparam logic [2:0] OP_CHECK = 3'd1;
	localparam logic [2:0] OP_DIV   = 3'd2;
	localparam logic [2:0] OP_STORE = 3'd3;
	localparam logic [2:0] OP_PREP  = 3'd4;
	localparam logic [2:0] OP_EMIT  = 3'd5;
	localparam logic [2:0] OP_INVAL = 3'd6;
	localparam logic [2:0] OP_NOP   = 3'd7;

	// jump conditions
	localparam logic [2:0] C_NEVER      = 3'd0;
	localparam logic [2:0] C_ALWAYS     = 3'd1;
	localparam logic [2:0] C_GOOD       = 3'd2;
	localparam logic [2:0] C_CHUNK_MORE = 3'd3;
	localparam logic [2:0] C_MORE       = 3'd4;
	localparam logic [2:0] C_K_NZ       = 3'd5;

	typedef struct packed {
		logic [2:0]       op;
		logic [2:0]       cond;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic good_radix;
		logic chunk_more;
		logic more_digits;
		logic k_nonzero;
	} flags_t;

endpackage

@@ sv/ritd_ram.sv @@
`timescale 1ns / 1ps
module ritd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/ritd_useq.sv @@
`timescale 1ns / 1ps
module ritd_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            hold,
	input  ritd_pkg::flags_t flags,
	output ritd_pkg::ctrl_t  ctrl
);

	import ritd_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic             jump;

	// microprogram: one control word per step
	function automatic ctrl_t rom(input logic [UPC_W-1:0] a);
		ctrl_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: UPC_W'(0)};
		unique case (a)
			3'd0: w = '{op: OP_WAIT,  cond: C_NEVER,      target: UPC_W'(0)};
			3'd1: w = '{op: OP_CHECK, cond: C_GOOD,       target: UPC_W'(4)};
			3'd2: w = '{op: OP_INVAL, cond: C_ALWAYS,     target: UPC_W'(0)};
			3'd3: w = '{op: OP_NOP,   cond: C_ALWAYS,     target: UPC_W'(0)};
			3'd4: w = '{op: OP_DIV,   cond: C_CHUNK_MORE, target: UPC_W'(4)};
			3'd5: w = '{op: OP_STORE, cond: C_MORE,       target: UPC_W'(4)};
			3'd6: w = '{op: OP_PREP,  cond: C_NEVER,      target: UPC_W'(0)};
			3'd7: w = '{op: OP_EMIT,  cond: C_K_NZ,       target: UPC_W'(7)};
			default: w = '{op: OP_NOP, cond: C_ALWAYS, target: UPC_W'(0)};
		endcase
		return w;
	endfunction

	assign ctrl = rom(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			C_ALWAYS:     jump = 1'b1;
			C_GOOD:       jump = flags.good_radix;
			C_CHUNK_MORE: jump = flags.chunk_more;
			C_MORE:       jump = flags.more_digits;
			C_K_NZ:       jump = flags.k_nonzero;
			default:      jump = 1'b0;
		endcase
	end

	// step counter wraps from the last step back to the wait step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= '0;
		end else if (!hold) begin
			upc_q <= jump ? ctrl.target : upc_q + UPC_W'(1);
		end
	end

endmodule

@@ sv/radix_integer_to_digits_core.sv @@
`timescale 1ns / 1ps
// channel   dir  fields (lowest bit up)                          transfer when
// s_axis    in   tdata: value[63:0], radix[68:64], zero pad      s_tvalid & s_tready
// m_axis    out  tdata: digit_char[6:0], digit_count[13:7], pad  m_tvalid & m_tready
//                tuser: invalid_radix, tlast: last
//
// division: each digit takes 8 steps of 8 quotient bits, then a store step,
// and a value with d digits repeats this d times before its d digits are emitted;
// the steps run on the shared 8-bit-per-cycle long-division unit.
// a bad radix gives its single transfer from the invalid step, which follows the check step.
// reset clears the step counter and the output valid; the digit store needs no clearing.
// a stalled output holds the emit or invalid step; input is taken only in the wait step.
module radix_integer_to_digits_core #(
	parameter int MAX_DIGITS = ritd_pkg::MAX_DIGITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ritd_pkg::S_TDATA_W-1:0] s_tdata,  // value, radix
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ritd_pkg::M_TDATA_W-1:0] m_tdata,  // digit_char, digit_count
	output logic                           m_tuser,  // invalid_radix
	output logic                           m_tlast
);

	import ritd_pkg::*;

	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

	ctrl_t  ctrl;
	flags_t flags;
	logic   hold;

	// datapath registers
	logic [VALUE_W-1:0] val_q;
	logic [RADIX_W-1:0] radix_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [2:0]         chunk_q;
	logic [CNT_W-1:0]   n_q;
	logic [ADDR_W-1:0]  k_q;

	// output register
	logic                 m_valid_q;
	logic [CHAR_W-1:0]    m_char_q;
	logic [COUNT_W-1:0]   m_count_q;
	logic                 m_inval_q;
	logic                 m_last_q;

	logic                 slot_busy;
	logic                 out_ld;
	logic [CHUNK_W-1:0]   q_byte;
	logic [DIGIT_W-1:0]   rem_nxt;
	logic                 ram_we;
	logic                 ram_re;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [DIGIT_W-1:0]   ram_rdata;

	ritd_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.hold   (hold),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	ritd_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (n_q[ADDR_W-1:0]),
		.wdata (rem_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign slot_busy = m_valid_q && !m_tready;

	// a step stalls on a missing input or a full output slot
	always_comb begin
		unique case (ctrl.op)
			OP_WAIT:          hold = !s_tvalid;
			OP_EMIT, OP_INVAL: hold = slot_busy;
			default:          hold = 1'b0;
		endcase
	end

	assign s_tready = (ctrl.op == OP_WAIT);
	assign out_ld   = ((ctrl.op == OP_EMIT) || (ctrl.op == OP_INVAL)) && !hold;

	// eight restoring division steps on the top byte of the dividend
	always_comb begin
		logic [DIGIT_W:0] t;
		logic [DIGIT_W-1:0] r;
		r      = rem_q;
		q_byte = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			t = {r, val_q[VALUE_W-CHUNK_W+i]};
			if (t >= radix_q) begin
				q_byte[i] = 1'b1;
				t         = t - radix_q;
			end
			r = t[DIGIT_W-1:0];
		end
		rem_nxt = r;
	end

	assign flags.good_radix  = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);
	assign flags.chunk_more  = (chunk_q != 3'd7);
	assign flags.more_digits = (val_q != '0)
		&& (({1'b0, n_q} + (CNT_W+1)'(1)) < (CNT_W+1)'(MAX_DIGITS));
	assign flags.k_nonzero   = (k_q != '0);

	assign ram_we    = (ctrl.op == OP_STORE);
	assign ram_re    = (ctrl.op == OP_PREP) || (out_ld && (ctrl.op == OP_EMIT) && (k_q != '0));
	assign ram_raddr = (ctrl.op == OP_PREP) ? ADDR_W'(n_q - CNT_W'(1)) : k_q - ADDR_W'(1);

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_WAIT: begin
				if (s_tvalid) begin
					val_q   <= s_tdata[VALUE_W-1:0];
					radix_q <= s_tdata[VALUE_W +: RADIX_W];
				end
			end
			OP_CHECK: begin
				n_q     <= '0;
				rem_q   <= '0;
				chunk_q <= '0;
			end
			OP_DIV: begin
				// quotient bits shift in below, so val_q ends as the quotient
				val_q   <= {val_q[VALUE_W-CHUNK_W-1:0], q_byte};
				rem_q   <= rem_nxt;
				chunk_q <= chunk_q + 3'd1;
			end
			OP_STORE: begin
				n_q     <= n_q + CNT_W'(1);
				rem_q   <= '0;
				chunk_q <= '0;
			end
			OP_PREP: begin
				k_q <= ADDR_W'(n_q - CNT_W'(1));
			end
			OP_EMIT: begin
				if (!hold && (k_q != '0)) begin
					k_q <= k_q - ADDR_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_ld) begin
			if (ctrl.op == OP_INVAL) begin
				m_char_q  <= '0;
				m_count_q <= '0;
				m_inval_q <= 1'b1;
				m_last_q  <= 1'b1;
			end else begin
				m_char_q  <= GLYPHS[ram_rdata];
				m_count_q <= COUNT_W'(n_q);
				m_inval_q <= 1'b0;
				m_last_q  <= (k_q == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ld) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(M_TDATA_W - CHAR_W - COUNT_W)'(0), m_count_q, m_char_q};
	assign m_tuser  = m_inval_q;
	assign m_tlast  = m_last_q;

	// a bad radix is a single result that closes its conversion
	a_inval_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata[CHAR_W +: COUNT_W] == '0))
		else $error("invalid-radix transfer without last or with nonzero count");

	// a good conversion always reports between one and the limit of digits
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[CHAR_W +: COUNT_W] != '0)
			&& (m_tdata[CHAR_W +: COUNT_W] <= COUNT_W'(MAX_DIGITS)))
		else $error("digit count out of range");

	// the digit counter never passes the store depth
	a_n_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.op == OP_STORE |-> ({1'b0, n_q} < (CNT_W+1)'(MAX_DIGITS)))
		else $error("digit store overrun");

	// the last digit loaded ends the emit loop
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld && ctrl.op == OP_EMIT && k_q == '0 |=> s_tready)
		else $error("sequencer did not return to wait after last digit");

endmodule
